>>> hdl/ietl_pkg.sv
// package: shared types, codes and constants of the interval exception table
package ietl_pkg;

    localparam int unsigned TableDepthDefault = 256;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // action kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_RETRY = 2'd1;
    localparam logic [1:0] KIND_JUMP  = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    // status codes
    localparam logic [3:0] ST_OK             = 4'd0;
    localparam logic [3:0] ST_HIT            = 4'd1;
    localparam logic [3:0] ST_MISS           = 4'd2;
    localparam logic [3:0] ST_BOUNDARY       = 4'd3;
    localparam logic [3:0] ST_PREDICATE      = 4'd4;
    localparam logic [3:0] ST_ACTION         = 4'd5;
    localparam logic [3:0] ST_UNSORTED       = 4'd6;
    localparam logic [3:0] ST_OVERLAP        = 4'd7;
    localparam logic [3:0] ST_GROUP_MISMATCH = 4'd8;
    localparam logic [3:0] ST_GROUP_FULL     = 4'd9;
    localparam logic [3:0] ST_TABLE_FULL     = 4'd10;

    // configuration register indexes
    localparam logic [2:0] REG_SUP_VEC  = 3'd0;
    localparam logic [2:0] REG_FAULT_EM = 3'd1;
    localparam logic [2:0] REG_PF_VEC   = 3'd2;
    localparam logic [2:0] REG_USER_LIM = 3'd3;
    localparam logic [2:0] REG_GRP_LIM  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_RANGE_RD,
        S_RANGE_CMP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;        // reset table bookkeeping
        logic app_check;    // evaluate append checks and commit when clean
        logic srch_init;    // lo = 0, hi = count
        logic srch_rd;      // read entry at mid
        logic srch_step;    // narrow interval from read data
        logic top_rd;       // read entry at lo-1
        logic top_cap;      // capture top record, set scan index
        logic scan_rd;      // read entry at scan index
        logic scan_step;    // evaluate scanned entry
        logic miss;         // finish with miss
        logic ok;           // finish with ok
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic srch_done;    // lo == hi
        logic lo_zero;      // lo == 0
        logic top_out;      // address outside top interval
        logic scan_hit;     // scanned entry matched
        logic scan_end;     // group exhausted
    } t_stat;

    // predicate validity against current registers
    function automatic logic pred_ok(input logic [31:0] vm, input logic [31:0] em,
                                     input logic [31:0] ev, input logic [31:0] sup,
                                     input logic [31:0] fem, input logic [4:0] pfv);
        logic [31:0] pf_bit;
        pf_bit = 32'd1 << pfv;
        pred_ok = (vm != 32'd0) && ((vm & ~sup) == 32'd0) && ((ev & ~em) == 32'd0)
                  && ((em & ~fem) == 32'd0) && !((em != 32'd0) && (vm != pf_bit));
    endfunction

endpackage

>>> hdl/ietl_ctrl.sv
// controller: sequences clear, append and lookup over the datapath
module ietl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_command,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_load,
    output ietl_pkg::t_ctrl   o_ctrl,
    input  ietl_pkg::t_stat   i_stat
);
    ietl_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;

    assign o_in_stall  = (r_state != ietl_pkg::S_IDLE) || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_load      = accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ietl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ietl_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        ietl_pkg::CMD_CLEAR: begin
                            o_ctrl.clear = 1'b1;
                            n_state = ietl_pkg::S_DONE;
                        end
                        ietl_pkg::CMD_APPEND: n_state = ietl_pkg::S_APPEND;
                        ietl_pkg::CMD_LOOKUP: begin
                            o_ctrl.srch_init = 1'b1;
                            n_state = ietl_pkg::S_SEARCH_RD;
                        end
                        default: begin
                            o_ctrl.ok = 1'b1;
                            n_state = ietl_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ietl_pkg::S_APPEND: begin
                o_ctrl.app_check = 1'b1;
                n_state = ietl_pkg::S_DONE;
            end
            ietl_pkg::S_SEARCH_RD: begin
                if (i_stat.srch_done) begin
                    if (i_stat.lo_zero) begin
                        o_ctrl.miss = 1'b1;
                        n_state = ietl_pkg::S_DONE;
                    end else begin
                        o_ctrl.top_rd = 1'b1;
                        n_state = ietl_pkg::S_RANGE_RD;
                    end
                end else begin
                    o_ctrl.srch_rd = 1'b1;
                    n_state = ietl_pkg::S_SEARCH_CMP;
                end
            end
            ietl_pkg::S_SEARCH_CMP: begin
                o_ctrl.srch_step = 1'b1;
                n_state = ietl_pkg::S_SEARCH_RD;
            end
            ietl_pkg::S_RANGE_RD: begin
                o_ctrl.top_cap = 1'b1;
                n_state = ietl_pkg::S_RANGE_CMP;
            end
            ietl_pkg::S_RANGE_CMP: begin
                if (i_stat.top_out) begin
                    o_ctrl.miss = 1'b1;
                    n_state = ietl_pkg::S_DONE;
                end else begin
                    o_ctrl.scan_rd = 1'b1;
                    n_state = ietl_pkg::S_SCAN_CMP;
                end
            end
            ietl_pkg::S_SCAN_RD: begin
                o_ctrl.scan_rd = 1'b1;
                n_state = ietl_pkg::S_SCAN_CMP;
            end
            ietl_pkg::S_SCAN_CMP: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_hit || i_stat.scan_end) begin
                    n_state = ietl_pkg::S_DONE;
                end else begin
                    n_state = ietl_pkg::S_SCAN_RD;
                end
            end
            ietl_pkg::S_DONE: begin
                n_out_valid = 1'b1;
                n_state = ietl_pkg::S_IDLE;
            end
            default: n_state = ietl_pkg::S_IDLE;
        endcase
    end
endmodule

>>> hdl/ietl_dp.sv
// datapath: record memory, append checks, binary search and group scan
module ietl_dp #(
    parameter int unsigned TABLE_DEPTH = ietl_pkg::TableDepthDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [63:0]       i_base_address,
    input  logic [63:0]       i_region_size,
    input  logic [31:0]       i_vector_mask,
    input  logic [31:0]       i_error_mask,
    input  logic [31:0]       i_error_value,
    input  logic [1:0]        i_action_kind,
    input  logic [63:0]       i_action_target,
    input  logic [63:0]       i_lookup_address,
    input  logic [31:0]       i_lookup_vector,
    input  logic [31:0]       i_lookup_error_code,
    input  logic [31:0]       i_sup_vec,
    input  logic [31:0]       i_fault_em,
    input  logic [4:0]        i_pf_vec,
    input  logic [63:0]       i_user_lim,
    input  logic [4:0]        i_grp_lim,
    input  ietl_pkg::t_ctrl   i_ctrl,
    output ietl_pkg::t_stat   o_stat,
    output logic [3:0]        o_status,
    output logic [1:0]        o_found_kind,
    output logic [63:0]       o_found_target,
    output logic [8:0]        o_entry_count
);
    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned RW = 64 + 64 + 32 + 32 + 32 + 2 + 64;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] size;
        logic [31:0] vm;
        logic [31:0] em;
        logic [31:0] ev;
        logic [1:0]  kind;
        logic [63:0] target;
    } t_rec;

    // record memory, one write and one registered read port
    t_rec mem [TABLE_DEPTH];
    t_rec r_rd;
    logic [AW-1:0] rd_addr;
    logic rd_en;

    // captured item
    logic [63:0] r_base, r_size, r_target, r_addr;
    logic [31:0] r_vm, r_em, r_ev, r_lvec, r_code;
    logic [1:0]  r_kind;

    // bookkeeping
    logic [CW-1:0] r_count;
    logic [63:0] r_last_base, r_last_end;
    logic [4:0]  r_group;

    // search and scan
    logic [CW-1:0] r_lo, r_hi, mid;
    logic [AW-1:0] r_idx;
    logic [63:0] r_top_base, r_top_size;

    // result
    logic [3:0]  r_status;
    logic [1:0]  r_fkind;
    logic [63:0] r_ftarget;

    // capture input item
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_base   <= i_base_address;
            r_size   <= i_region_size;
            r_vm     <= i_vector_mask;
            r_em     <= i_error_mask;
            r_ev     <= i_error_value;
            r_kind   <= i_action_kind;
            r_target <= i_action_target;
            r_addr   <= i_lookup_address;
            r_lvec   <= i_lookup_vector;
            r_code   <= i_lookup_error_code;
        end
    end

    // append checks
    logic [64:0] sum;
    logic [63:0] app_end;
    logic [5:0]  new_grp;
    logic [3:0]  app_st;
    logic        cnt_full;
    assign sum     = {1'b0, r_base} + {1'b0, r_size};
    assign app_end = sum[63:0];
    assign cnt_full = (r_count >= CW'(TABLE_DEPTH));
    always_comb begin
        new_grp = 6'd1;
        app_st  = ietl_pkg::ST_OK;
        if (r_base == 64'd0 || r_size == 64'd0 || sum[64] || app_end > i_user_lim) begin
            app_st = ietl_pkg::ST_BOUNDARY;
        end else if (!ietl_pkg::pred_ok(r_vm, r_em, r_ev, i_sup_vec, i_fault_em, i_pf_vec)) begin
            app_st = ietl_pkg::ST_PREDICATE;
        end else if (r_kind == ietl_pkg::KIND_BAD) begin
            app_st = ietl_pkg::ST_ACTION;
        end else if (r_kind == ietl_pkg::KIND_JUMP
                     && (r_target == 64'd0 || r_target >= i_user_lim)) begin
            app_st = ietl_pkg::ST_ACTION;
        end else if (r_kind != ietl_pkg::KIND_JUMP && r_target != 64'd0) begin
            app_st = ietl_pkg::ST_ACTION;
        end else if (r_count != '0 && r_base < r_last_base) begin
            app_st = ietl_pkg::ST_UNSORTED;
        end else if (r_count != '0 && r_base == r_last_base) begin
            new_grp = {1'b0, r_group} + 6'd1;
            if (app_end != r_last_end) begin
                app_st = ietl_pkg::ST_GROUP_MISMATCH;
            end else if (new_grp > {1'b0, i_grp_lim}) begin
                app_st = ietl_pkg::ST_GROUP_FULL;
            end else if (cnt_full) begin
                app_st = ietl_pkg::ST_TABLE_FULL;
            end
        end else if (r_count != '0 && r_base < r_last_end) begin
            app_st = ietl_pkg::ST_OVERLAP;
        end else if (cnt_full) begin
            app_st = ietl_pkg::ST_TABLE_FULL;
        end
    end

    // memory write on a clean append
    always_ff @(posedge i_clk) begin
        if (i_ctrl.app_check && app_st == ietl_pkg::ST_OK) begin
            mem[r_count[AW-1:0]] <= '{r_base, r_size, r_vm, r_em, r_ev, r_kind, r_target};
        end
    end

    // read address selection
    assign mid = r_lo + ((r_hi - r_lo) >> 1);
    logic [CW-1:0] lo_m1;
    assign lo_m1 = r_lo - CW'(1);
    always_comb begin
        rd_en   = i_ctrl.srch_rd || i_ctrl.top_rd || i_ctrl.scan_rd;
        rd_addr = r_idx;
        if (i_ctrl.srch_rd) begin
            rd_addr = mid[AW-1:0];
        end else if (i_ctrl.top_rd) begin
            rd_addr = lo_m1[AW-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // scan predicate on the entry just read
    logic [64:0] top_end;
    logic        match, same;
    assign top_end = {1'b0, r_rd.base} + {1'b0, r_rd.size};
    assign same  = (r_rd.base == r_top_base) && (r_rd.size == r_top_size);
    assign match = ietl_pkg::pred_ok(r_rd.vm, r_rd.em, r_rd.ev, i_sup_vec, i_fault_em, i_pf_vec)
                   && ((r_rd.vm & r_lvec) != 32'd0) && ((r_code & r_rd.em) == r_rd.ev);

    assign o_stat.srch_done = (r_lo == r_hi);
    assign o_stat.lo_zero   = (r_lo == '0);
    assign o_stat.top_out   = ({1'b0, r_addr} >= top_end);
    assign o_stat.scan_hit  = same && match;
    assign o_stat.scan_end  = !same || (r_idx == '0);

    // control and search registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last_base <= '0;
            r_last_end  <= '0;
            r_group     <= '0;
        end else if (i_ctrl.clear) begin
            r_count     <= '0;
            r_last_base <= '0;
            r_last_end  <= '0;
            r_group     <= '0;
        end else if (i_ctrl.app_check && app_st == ietl_pkg::ST_OK) begin
            r_count     <= r_count + CW'(1);
            r_last_base <= r_base;
            r_last_end  <= app_end;
            r_group     <= new_grp[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.srch_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_ctrl.srch_step) begin
            if (r_addr < r_rd.base) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid + CW'(1);
            end
        end
        if (i_ctrl.top_cap) begin
            r_top_base <= r_rd.base;
            r_top_size <= r_rd.size;
            r_idx      <= lo_m1[AW-1:0];
        end else if (i_ctrl.scan_step && !o_stat.scan_end) begin
            r_idx <= r_idx - AW'(1);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_load || i_ctrl.clear || i_ctrl.ok) begin
            r_status  <= ietl_pkg::ST_OK;
            r_fkind   <= '0;
            r_ftarget <= '0;
        end
        if (i_ctrl.app_check) begin
            r_status <= app_st;
        end
        if (i_ctrl.miss || (i_ctrl.scan_step && !o_stat.scan_hit && o_stat.scan_end)) begin
            r_status <= ietl_pkg::ST_MISS;
        end
        if (i_ctrl.scan_step && o_stat.scan_hit) begin
            r_status  <= ietl_pkg::ST_HIT;
            r_fkind   <= r_rd.kind;
            r_ftarget <= r_rd.target;
        end
    end

    assign o_status       = r_status;
    assign o_found_kind   = r_fkind;
    assign o_found_target = r_ftarget;
    assign o_entry_count  = 9'(r_count);
endmodule

>>> hdl/interval_exception_table_lookup.sv
// top level: configuration registers, controller and datapath
// An item takes one command. A lookup runs a binary search over the records,
// one registered read per probe; it ends in a miss when the address lies
// below every base or past the end of the interval found. Otherwise it scans
// the matching group backward from that record, one registered read per
// step, through the single read port of the record memory. One item is
// worked at a time; a result held at the output under stall holds the next
// item off.
module interval_exception_table_lookup #(
    parameter int unsigned TABLE_DEPTH = ietl_pkg::TableDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_base_address,
    input  logic [63:0] i_region_size,
    input  logic [31:0] i_vector_mask,
    input  logic [31:0] i_error_mask,
    input  logic [31:0] i_error_value,
    input  logic [1:0]  i_action_kind,
    input  logic [63:0] i_action_target,
    input  logic [63:0] i_lookup_address,
    input  logic [31:0] i_lookup_vector,
    input  logic [31:0] i_lookup_error_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic [1:0]  o_found_kind,
    output logic [63:0] o_found_target,
    output logic [8:0]  o_entry_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    logic [31:0] r_sup_vec, r_fault_em;
    logic [4:0]  r_pf_vec, r_grp_lim;
    logic [63:0] r_user_lim;
    logic load;
    ietl_pkg::t_ctrl ctrl;
    ietl_pkg::t_stat stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sup_vec  <= 32'hFFFF_FFFF;
            r_fault_em <= 32'h0000_FFFF;
            r_pf_vec   <= 5'd14;
            r_user_lim <= 64'h0000_7FFF_FFFF_F000;
            r_grp_lim  <= 5'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ietl_pkg::REG_SUP_VEC:  r_sup_vec  <= i_cfg_data[31:0];
                ietl_pkg::REG_FAULT_EM: r_fault_em <= i_cfg_data[31:0];
                ietl_pkg::REG_PF_VEC:   r_pf_vec   <= i_cfg_data[4:0];
                ietl_pkg::REG_USER_LIM: r_user_lim <= i_cfg_data;
                ietl_pkg::REG_GRP_LIM:  r_grp_lim  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    ietl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_command(i_command), .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_load(load), .o_ctrl(ctrl), .i_stat(stat)
    );

    ietl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(load),
        .i_base_address(i_base_address), .i_region_size(i_region_size),
        .i_vector_mask(i_vector_mask), .i_error_mask(i_error_mask),
        .i_error_value(i_error_value), .i_action_kind(i_action_kind),
        .i_action_target(i_action_target), .i_lookup_address(i_lookup_address),
        .i_lookup_vector(i_lookup_vector), .i_lookup_error_code(i_lookup_error_code),
        .i_sup_vec(r_sup_vec), .i_fault_em(r_fault_em), .i_pf_vec(r_pf_vec),
        .i_user_lim(r_user_lim), .i_grp_lim(r_grp_lim), .i_ctrl(ctrl), .o_stat(stat),
        .o_status(o_status), .o_found_kind(o_found_kind), .o_found_target(o_found_target),
        .o_entry_count(o_entry_count)
    );
endmodule

>>> hdl/ietl_chk.sv
// checker: port-level properties of the table block, bound to the top level
module ietl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_status,
    input logic [1:0]  o_found_kind,
    input logic [63:0] o_found_target
);
    // results held under stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("result changed under stall");

    // no new item while a result waits stalled
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("item taken while result stalled");

    // an accepted item leaves no result showing in the next cycle
    a_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("result shown right after item taken");

    // found fields are zero unless hit
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ietl_pkg::ST_HIT
        |-> o_found_kind == 2'd0 && o_found_target == 64'd0)
        else $error("found fields set without hit");

    // status in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ietl_pkg::ST_TABLE_FULL)
        else $error("status out of range");
endmodule

bind interval_exception_table_lookup ietl_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_status(o_status),
    .o_found_kind(o_found_kind), .o_found_target(o_found_target)
);

>>> tb/tb_interval_exception_table_lookup.sv
// testbench for the interval exception table: directed and random items checked against a predictor
module tb_interval_exception_table_lookup;

    localparam int unsigned Depth = 256;
    localparam logic [1:0] CmdUnused = 2'd3;

    typedef struct {
        logic [1:0]  command;
        logic [63:0] base;
        logic [63:0] size;
        logic [31:0] vmask;
        logic [31:0] emask;
        logic [31:0] evalue;
        logic [1:0]  kind;
        logic [63:0] target;
        logic [63:0] addr;
        logic [31:0] vec;
        logic [31:0] code;
    } t_item;

    typedef struct {
        logic [3:0]  status;
        logic [1:0]  kind;
        logic [63:0] target;
        logic [8:0]  count;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_command = '0;
    logic [63:0] i_base_address = '0;
    logic [63:0] i_region_size = '0;
    logic [31:0] i_vector_mask = '0;
    logic [31:0] i_error_mask = '0;
    logic [31:0] i_error_value = '0;
    logic [1:0]  i_action_kind = '0;
    logic [63:0] i_action_target = '0;
    logic [63:0] i_lookup_address = '0;
    logic [31:0] i_lookup_vector = '0;
    logic [31:0] i_lookup_error_code = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_status;
    logic [1:0]  o_found_kind;
    logic [63:0] o_found_target;
    logic [8:0]  o_entry_count;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    interval_exception_table_lookup dut (.*);

    // predicted table contents and bookkeeping
    logic [63:0] rec_base [Depth];
    logic [63:0] rec_size [Depth];
    logic [31:0] rec_vmask [Depth];
    logic [31:0] rec_emask [Depth];
    logic [31:0] rec_evalue [Depth];
    logic [1:0]  rec_kind [Depth];
    logic [63:0] rec_target [Depth];
    int unsigned rec_count = 0;
    logic [63:0] last_base = '0;
    logic [63:0] last_end = '0;
    int unsigned group_size = 0;

    // predicted register contents
    logic [31:0] sup_vec = 32'hFFFF_FFFF;
    logic [31:0] fault_em = 32'h0000_FFFF;
    logic [4:0]  pf_vec = 5'd14;
    logic [63:0] user_lim = 64'd140737488351232;
    logic [4:0]  grp_lim = 5'd8;

    t_answer     pending_results[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [63:0] gen_cursor = 64'h1000;
    logic        gen_have_last = 1'b0;
    logic [63:0] gen_last_base;
    logic [63:0] gen_last_size;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("interval_exception_table_lookup test failed");
        $finish;
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h (t=%0t)", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result status", 64'(o_status), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_found_kind !== want.kind)
                    report_mismatch("kind", 64'(o_found_kind), 64'(want.kind));
                if (o_found_target !== want.target)
                    report_mismatch("target", o_found_target, want.target);
                if (o_entry_count !== want.count)
                    report_mismatch("count", 64'(o_entry_count), 64'(want.count));
            end
        end
    end

    function automatic logic predicate_valid(logic [31:0] vm, logic [31:0] em, logic [31:0] ev);
        logic [31:0] pf_bit;
        pf_bit = 32'd1 << pf_vec;
        return (vm != 0) && ((vm & ~sup_vec) == 0) && ((ev & ~em) == 0)
               && ((em & ~fault_em) == 0) && !((em != 0) && (vm != pf_bit));
    endfunction

    // append checks in priority order; commits the record when clean
    function automatic logic [3:0] append_record(t_item it);
        logic [64:0] sum;
        int unsigned new_group;
        sum = {1'b0, it.base} + {1'b0, it.size};
        if (it.base == 0 || it.size == 0 || sum[64] || sum[63:0] > user_lim)
            return ietl_pkg::ST_BOUNDARY;
        if (!predicate_valid(it.vmask, it.emask, it.evalue)) return ietl_pkg::ST_PREDICATE;
        if (it.kind == ietl_pkg::KIND_BAD) return ietl_pkg::ST_ACTION;
        if (it.kind == ietl_pkg::KIND_JUMP) begin
            if (it.target == 0 || it.target >= user_lim) return ietl_pkg::ST_ACTION;
        end else if (it.target != 0) begin
            return ietl_pkg::ST_ACTION;
        end
        new_group = 1;
        if (rec_count > 0) begin
            if (it.base < last_base) return ietl_pkg::ST_UNSORTED;
            if (it.base == last_base) begin
                if (sum[63:0] != last_end) return ietl_pkg::ST_GROUP_MISMATCH;
                new_group = group_size + 1;
                if (new_group > grp_lim) return ietl_pkg::ST_GROUP_FULL;
            end else if (it.base < last_end) begin
                return ietl_pkg::ST_OVERLAP;
            end
        end
        if (rec_count >= Depth) return ietl_pkg::ST_TABLE_FULL;
        rec_base[rec_count] = it.base;
        rec_size[rec_count] = it.size;
        rec_vmask[rec_count] = it.vmask;
        rec_emask[rec_count] = it.emask;
        rec_evalue[rec_count] = it.evalue;
        rec_kind[rec_count] = it.kind;
        rec_target[rec_count] = it.target;
        rec_count++;
        last_base = it.base;
        last_end = sum[63:0];
        group_size = new_group & 31;
        return ietl_pkg::ST_OK;
    endfunction

    // binary search, then backward scan of the group
    function automatic t_answer search_table(t_item it);
        t_answer a;
        int unsigned lo, hi, mid, top;
        int idx;
        a = '{ietl_pkg::ST_MISS, 2'd0, 64'd0, 9'd0};
        lo = 0;
        hi = rec_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (it.addr < rec_base[mid]) hi = mid;
            else lo = mid + 1;
        end
        if (lo == 0) return a;
        top = lo - 1;
        if (it.addr >= rec_base[top] + rec_size[top]) return a;
        for (idx = top; idx >= 0; idx--) begin
            if (rec_base[idx] != rec_base[top] || rec_size[idx] != rec_size[top]) break;
            if (predicate_valid(rec_vmask[idx], rec_emask[idx], rec_evalue[idx])
                && (rec_vmask[idx] & it.vec) != 0
                && (it.code & rec_emask[idx]) == rec_evalue[idx]) begin
                a.status = ietl_pkg::ST_HIT;
                a.kind = rec_kind[idx];
                a.target = rec_target[idx];
                return a;
            end
        end
        return a;
    endfunction

    function automatic t_answer predict_result(t_item it);
        t_answer a;
        a = '{ietl_pkg::ST_OK, 2'd0, 64'd0, 9'd0};
        case (it.command)
            ietl_pkg::CMD_CLEAR: begin
                rec_count = 0;
                last_base = 0;
                last_end = 0;
                group_size = 0;
            end
            ietl_pkg::CMD_APPEND: a.status = append_record(it);
            ietl_pkg::CMD_LOOKUP: a = search_table(it);
            default: ;
        endcase
        a.count = rec_count[8:0];
        return a;
    endfunction

    // drive one item, wait for acceptance, then maybe idle
    task automatic send_item(t_item it);
        i_in_valid <= 1'b1;
        i_command <= it.command;
        i_base_address <= it.base;
        i_region_size <= it.size;
        i_vector_mask <= it.vmask;
        i_error_mask <= it.emask;
        i_error_value <= it.evalue;
        i_action_kind <= it.kind;
        i_action_target <= it.target;
        i_lookup_address <= it.addr;
        i_lookup_vector <= it.vec;
        i_lookup_error_code <= it.code;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_result(it));
        if (it.command == ietl_pkg::CMD_CLEAR) gen_have_last = 1'b0;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // hold the sender off until every expected result is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [63:0] data);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            ietl_pkg::REG_SUP_VEC:  sup_vec = data[31:0];
            ietl_pkg::REG_FAULT_EM: fault_em = data[31:0];
            ietl_pkg::REG_PF_VEC:   pf_vec = data[4:0];
            ietl_pkg::REG_USER_LIM: user_lim = data;
            ietl_pkg::REG_GRP_LIM:  grp_lim = data[4:0];
            default: ;
        endcase
    endtask

    function automatic t_item blank_item(logic [1:0] command);
        t_item it;
        it = '{command, 64'd0, 64'd0, 32'd0, 32'd0, 32'd0, ietl_pkg::KIND_NONE, 64'd0, 64'd0,
               32'd0, 32'd0};
        return it;
    endfunction

    function automatic t_item rec_item(logic [63:0] base, logic [63:0] size, logic [31:0] vm,
                                       logic [31:0] em, logic [31:0] ev, logic [1:0] kind,
                                       logic [63:0] target);
        t_item it;
        it = blank_item(ietl_pkg::CMD_APPEND);
        it.base = base;
        it.size = size;
        it.vmask = vm;
        it.emask = em;
        it.evalue = ev;
        it.kind = kind;
        it.target = target;
        return it;
    endfunction

    function automatic t_item probe_item(logic [63:0] addr, logic [31:0] vec, logic [31:0] code);
        t_item it;
        it = blank_item(ietl_pkg::CMD_LOOKUP);
        it.addr = addr;
        it.vec = vec;
        it.code = code;
        return it;
    endfunction

    function automatic t_item noise_item();
        t_item it;
        it = '{2'($urandom_range(3)), {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
               $urandom, $urandom, 2'($urandom_range(3)), {$urandom, $urandom},
               {$urandom, $urandom}, $urandom, $urandom};
        return it;
    endfunction

    // well-formed record that follows the previous one
    function automatic t_item next_record();
        t_item it;
        int v;
        logic [31:0] em;
        logic [1:0] kind;
        v = ($urandom_range(3) == 0) ? int'(pf_vec) : int'($urandom_range(31));
        em = (v == pf_vec && $urandom_range(1)) ? ($urandom & fault_em) : 32'd0;
        kind = 2'($urandom_range(2));
        it = rec_item(0, 0, 32'd1 << v, em, $urandom & em, kind,
                      (kind == ietl_pkg::KIND_JUMP) ? 64'($urandom_range(1, 1 << 20)) : 64'd0);
        if ($urandom_range(7) == 0) it.vmask |= $urandom & sup_vec;
        if (gen_have_last && $urandom_range(2) == 0) begin
            it.base = gen_last_base;
            it.size = gen_last_size;
        end else begin
            it.base = gen_cursor + 64'($urandom_range(64));
            it.size = 64'($urandom_range(1, 256));
            gen_cursor = it.base + it.size;
        end
        gen_have_last = 1'b1;
        gen_last_base = it.base;
        gen_last_size = it.size;
        return it;
    endfunction

    // lookup aimed mostly inside held intervals
    function automatic t_item next_probe();
        t_item it;
        int unsigned idx;
        int v;
        v = ($urandom_range(2) == 0) ? int'(pf_vec) : int'($urandom_range(31));
        it = probe_item({$urandom, $urandom}, 32'd1 << v, $urandom);
        if (rec_count > 0 && $urandom_range(9) != 0) begin
            idx = $urandom_range(rec_count - 1);
            it.addr = rec_base[idx] + ($urandom_range(5) == 0 ? rec_size[idx]
                                       : {32'd0, $urandom} % rec_size[idx]);
            if ($urandom_range(1)) it.code = (it.code & ~rec_emask[idx]) | rec_evalue[idx];
            if ($urandom_range(1)) it.vec = rec_vmask[idx] & -rec_vmask[idx];
        end
        return it;
    endfunction

    function automatic t_item fresh_clear();
        gen_cursor = 64'h1000 + 64'($urandom_range(4096));
        return blank_item(ietl_pkg::CMD_CLEAR);
    endfunction

    // empty table, unused command and append rejections other than group and table full
    task automatic test_append_checks();
        logic [31:0] pf;
        pf = 32'd1 << 14;
        send_item(probe_item(64'h1000, pf, 0));
        send_item(blank_item(CmdUnused));
        send_item(blank_item(ietl_pkg::CMD_CLEAR));
        send_item(rec_item(0, 64'h10, 1, 0, 0, ietl_pkg::KIND_NONE, 0));
        send_item(rec_item(64'h1000, 0, 1, 0, 0, ietl_pkg::KIND_NONE, 0));
        send_item(rec_item('1, 64'd2, 1, 0, 0, ietl_pkg::KIND_NONE, 0));
        send_item(rec_item(64'h7FFF_FFFF_F000, 64'h10, 1, 0, 0, ietl_pkg::KIND_NONE, 0));
        send_item(rec_item(64'h1000, 64'h100, 0, 0, 0, ietl_pkg::KIND_NONE, 0));
        send_item(rec_item(64'h1000, 64'h100, 32'h8, 32'h2, 32'h2, ietl_pkg::KIND_NONE, 0));
        send_item(rec_item(64'h1000, 64'h100, pf, 32'h2, 32'h3, ietl_pkg::KIND_NONE, 0));
        send_item(rec_item(64'h1000, 64'h100, pf, 32'h1_0000, 0, ietl_pkg::KIND_NONE, 0));
        send_item(rec_item(64'h1000, 64'h100, 1, 0, 0, ietl_pkg::KIND_BAD, 64'h10));
        send_item(rec_item(64'h1000, 64'h100, 1, 0, 0, ietl_pkg::KIND_RETRY, 64'h10));
        send_item(rec_item(64'h1000, 64'h100, 1, 0, 0, ietl_pkg::KIND_JUMP, 0));
        send_item(rec_item(64'h1000, 64'h100, 1, 0, 0, ietl_pkg::KIND_JUMP,
                           64'h7FFF_FFFF_F000));
        send_item(rec_item(64'h1000, 64'h100, pf, 32'h2, 32'h2, ietl_pkg::KIND_JUMP, 64'h4000));
        send_item(rec_item(64'h1000, 64'h80, 32'h8, 0, 0, ietl_pkg::KIND_RETRY, 0));
        send_item(rec_item(64'h1000, 64'h100, 32'h8, 0, 0, ietl_pkg::KIND_RETRY, 0));
        send_item(rec_item(64'h800, 64'h10, 1, 0, 0, ietl_pkg::KIND_NONE, 0));
        send_item(rec_item(64'h1080, 64'h10, 1, 0, 0, ietl_pkg::KIND_NONE, 0));
    endtask

    // lookups over the directed group
    task automatic test_lookup_paths();
        send_item(probe_item(64'h1010, 32'd1 << 14, 32'h2));
        send_item(probe_item(64'h10FF, 32'h8, '1));
        send_item(probe_item(64'h1100, 32'h8, 0));
        send_item(probe_item(64'hFFF, 32'h8, 0));
        send_item(probe_item('1, '1, '1));
    endtask

    // register extremes, group limit zero and predicate recheck on lookup
    task automatic test_registers();
        write_reg(ietl_pkg::REG_PF_VEC, 64'd31);
        send_item(probe_item(64'h1010, 32'd1 << 14, 32'h2));
        write_reg(ietl_pkg::REG_GRP_LIM, 64'd0);
        send_item(rec_item(64'h2000, 64'h40, 32'h10, 0, 0, ietl_pkg::KIND_NONE, 0));
        send_item(rec_item(64'h2000, 64'h40, 32'h20, 0, 0, ietl_pkg::KIND_NONE, 0));
        write_reg(ietl_pkg::REG_USER_LIM, '1);
        write_reg(ietl_pkg::REG_GRP_LIM, 64'd16);
        send_item(rec_item(64'hFFFF_FFFF_FFFF_FF00, 64'hFF, 32'h1, 0, 0, ietl_pkg::KIND_JUMP,
                           '1 - 1));
        send_item(probe_item(64'hFFFF_FFFF_FFFF_FFFE, 32'h1, 0));
        write_reg(ietl_pkg::REG_SUP_VEC, 64'd0);
        write_reg(ietl_pkg::REG_FAULT_EM, 64'hFFFF_FFFF);
        send_item(probe_item(64'h2010, 32'h10, 0));
        write_reg(ietl_pkg::REG_USER_LIM, 64'd0);
        send_item(rec_item(64'h3000, 64'h40, 32'h10, 0, 0, ietl_pkg::KIND_NONE, 0));
        write_reg(ietl_pkg::REG_SUP_VEC, 64'hFFFF_FFFF);
        write_reg(ietl_pkg::REG_FAULT_EM, 64'h0000_FFFF);
        write_reg(ietl_pkg::REG_PF_VEC, 64'd14);
        write_reg(ietl_pkg::REG_USER_LIM, 64'd140737488351232);
        write_reg(ietl_pkg::REG_GRP_LIM, 64'd8);
    endtask

    // fill the table to the top, then overflow it
    task automatic test_table_full();
        int tries;
        send_item(fresh_clear());
        tries = 0;
        while (rec_count < Depth && tries < 600) begin
            send_item(next_record());
            tries++;
        end
        send_item(next_record());
        repeat (20) send_item(next_probe());
    endtask

    // random sequences with random content plus noise
    task automatic test_random(int items, logic pause_midway);
        int r;
        for (int n = 0; n < items; n++) begin
            if (pause_midway && n == items / 2) wait_idle();
            r = $urandom_range(99);
            if (r < 3) send_item(fresh_clear());
            else if (r < 48) send_item(next_record());
            else if (r < 90) send_item(next_probe());
            else send_item(noise_item());
        end
    endtask

    task automatic random_config();
        write_reg(ietl_pkg::REG_SUP_VEC,
                  $urandom_range(3) == 0 ? {32'd0, $urandom} : 64'hFFFF_FFFF);
        write_reg(ietl_pkg::REG_FAULT_EM, {32'd0, $urandom});
        write_reg(ietl_pkg::REG_PF_VEC, 64'($urandom_range(31)));
        write_reg(ietl_pkg::REG_USER_LIM, $urandom_range(3) == 0 ? {$urandom, $urandom}
                                                                  : 64'h7FFF_FFFF_F000);
        write_reg(ietl_pkg::REG_GRP_LIM, 64'($urandom_range(1, 16)));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 19;
        recv_idle_pct = 77;
        test_append_checks();
        test_lookup_paths();
        test_registers();
        random_config();
        test_random(250, 1'b1);
        send_idle_pct = 77;
        recv_idle_pct = 19;
        random_config();
        test_random(250, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(ietl_pkg::REG_SUP_VEC, 64'hFFFF_FFFF);
        write_reg(ietl_pkg::REG_USER_LIM, 64'h7FFF_FFFF_F000);
        test_table_full();
        random_config();
        test_random(120, 1'b0);
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("interval_exception_table_lookup test passed");
        end else begin
            $display("interval_exception_table_lookup test failed");
        end
        $finish;
    end

endmodule
